@@ sv/dequ_pkg.sv @@
`timescale 1ns / 1ps

package dequ_pkg;

   localparam int ADDR_W  = 4;
   localparam int DEPTH   = 1 << ADDR_W;
   localparam int COUNT_W = ADDR_W + 1;
   localparam int WORD_W  = 32;

   typedef enum logic [2:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_CLEAR      = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic [2:0]               cmd;
      logic signed [WORD_W-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] pop_value;
      logic [1:0]               status;
      logic [COUNT_W-1:0]       item_count;
      logic                     is_empty;
   } rsp_type;

   typedef struct packed {
      logic               wr_en;
      logic               rd_en;
      logic [ADDR_W-1:0]  addr;
      logic [WORD_W-1:0]  wr_data;
   } mem_req_type;

   typedef struct packed {
      logic               pop_ok;
      logic [1:0]         status;
      logic [COUNT_W-1:0] item_count;
      logic               is_empty;
   } info_type;

endpackage

@@ sv/double_ended_queue_unit.sv @@
`timescale 1ns / 1ps

// Double-ended queue of 32-bit signed words in a 16-entry circular RAM. Each
// request beat carries one command (push front, push back, pop front, pop back
// or clear) and yields exactly one response beat with the popped word, a
// status code, the resulting count and an empty flag. A new command is taken
// every cycle as long as the response side keeps up; a stalled response holds
// off the request side. The RAM read data and the request's status are registered
// when a request beat is accepted, and the output register loads from them once
// the response side is free. Pops on an empty queue and pushes on a full one
// return an error status and leave the queue unchanged.
module double_ended_queue_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  dequ_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output dequ_pkg::rsp_type  rsp_data
);
   import dequ_pkg::*;

   mem_req_type       mem_req;
   info_type          info;
   logic [WORD_W-1:0] rd_data;
   logic              accept;
   logic              out_load;

   logic              stage_valid_ff, stage_valid_in;
   info_type          stage_info_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff;

   // The RAM read data stays put while the stage stalls, since a read is
   // only issued when a new beat is accepted.
   assign out_load  = stage_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !stage_valid_ff || out_load;
   assign accept    = req_valid && req_ready;

   dequ_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .req     (req_data),
      .mem_req (mem_req),
      .info    (info)
   );

   dequ_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   always_comb begin
      stage_valid_in = accept || (stage_valid_ff && !out_load);
      rsp_valid_in   = out_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_info_ff <= info;
      end
      if (out_load) begin
         rsp_data_ff.pop_value  <= stage_info_ff.pop_ok ? rd_data : '0;
         rsp_data_ff.status     <= stage_info_ff.status;
         rsp_data_ff.item_count <= stage_info_ff.item_count;
         rsp_data_ff.is_empty   <= stage_info_ff.is_empty;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ sv/dequ_mem.sv @@
`timescale 1ns / 1ps

module dequ_mem (
   input  logic                         clock,
   input  dequ_pkg::mem_req_type        mem_req,
   output logic [dequ_pkg::WORD_W-1:0]  rd_data
);
   import dequ_pkg::*;

   logic [WORD_W-1:0] store [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         store[mem_req.addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= store[mem_req.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/dequ_ctrl.sv @@
`timescale 1ns / 1ps

module dequ_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  dequ_pkg::req_type      req,
   output dequ_pkg::mem_req_type  mem_req,
   output dequ_pkg::info_type     info
);
   import dequ_pkg::*;

   logic [ADDR_W-1:0]  front_ff, front_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               full;
   logic               empty;
   logic [ADDR_W-1:0]  back_next;
   logic [ADDR_W-1:0]  back_last;

   assign full  = (count_ff == COUNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   // The depth is a power of two, so the index wraps by plain truncation.
   assign back_next = front_ff + count_ff[ADDR_W-1:0];
   assign back_last = front_ff + count_ff[ADDR_W-1:0] - ADDR_W'(1);

   always_comb begin
      front_in        = front_ff;
      count_in        = count_ff;
      mem_req.wr_en   = 1'b0;
      mem_req.rd_en   = 1'b0;
      mem_req.addr    = front_ff;
      mem_req.wr_data = req.push_value;
      info.pop_ok     = 1'b0;
      info.status     = ST_OK;
      unique case (cmd_type'(req.cmd))
         CMD_PUSH_FRONT: begin
            if (full) begin
               info.status = ST_FULL;
            end else begin
               front_in      = front_ff - ADDR_W'(1);
               count_in      = count_ff + COUNT_W'(1);
               mem_req.wr_en = accept;
               mem_req.addr  = front_ff - ADDR_W'(1);
            end
         end
         CMD_PUSH_BACK: begin
            if (full) begin
               info.status = ST_FULL;
            end else begin
               count_in      = count_ff + COUNT_W'(1);
               mem_req.wr_en = accept;
               mem_req.addr  = back_next;
            end
         end
         CMD_POP_FRONT: begin
            if (empty) begin
               info.status = ST_EMPTY;
            end else begin
               front_in      = front_ff + ADDR_W'(1);
               count_in      = count_ff - COUNT_W'(1);
               mem_req.rd_en = accept;
               mem_req.addr  = front_ff;
               info.pop_ok   = 1'b1;
            end
         end
         CMD_POP_BACK: begin
            if (empty) begin
               info.status = ST_EMPTY;
            end else begin
               count_in      = count_ff - COUNT_W'(1);
               mem_req.rd_en = accept;
               mem_req.addr  = back_last;
               info.pop_ok   = 1'b1;
            end
         end
         CMD_CLEAR: begin
            front_in = '0;
            count_in = '0;
         end
         default: begin
         end
      endcase
      info.item_count = count_in;
      info.is_empty   = (count_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
      end else if (accept) begin
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import dequ_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_ITEMS  = 1150;
   localparam int CALM_FROM     = 400;
   localparam int CALM_TO       = 800;
   localparam int SETTLE_CYCLES = 8;
   localparam int REPORT_CAP    = 100;

   // Command codes with no defined operation; the block must treat them as no-ops.
   localparam logic [2:0] CMD_SPARE_LO = 3'd5;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;

   localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;
   localparam logic [WORD_W-1:0] WORD_MAX = 32'h7fff_ffff;

   typedef struct {
      req_type beat;
      bit      drain_first;
   } queued_command_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   queued_command_type command_backlog[$];
   rsp_type            expected_replies[$];

   int  cycle_count = 0;
   int  commands_sent = 0;
   int  replies_seen = 0;
   int  error_count = 0;
   logic calm;

   // Shadow of the deque state.
   logic signed [WORD_W-1:0] shadow_words[DEPTH];
   logic [ADDR_W-1:0]        shadow_head = '0;
   logic [COUNT_W-1:0]       shadow_count = '0;

   double_ended_queue_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   assign calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

   function automatic rsp_type deque_step(req_type beat);
      rsp_type           reply;
      logic [ADDR_W-1:0] slot;
      reply = '0;
      reply.status = ST_OK;
      case (beat.cmd)
         CMD_PUSH_FRONT: begin
            if (shadow_count == COUNT_W'(DEPTH)) begin
               reply.status = ST_FULL;
            end else begin
               shadow_head = shadow_head - ADDR_W'(1);
               shadow_words[shadow_head] = beat.push_value;
               shadow_count = shadow_count + COUNT_W'(1);
            end
         end
         CMD_PUSH_BACK: begin
            if (shadow_count == COUNT_W'(DEPTH)) begin
               reply.status = ST_FULL;
            end else begin
               slot = shadow_head + shadow_count[ADDR_W-1:0];
               shadow_words[slot] = beat.push_value;
               shadow_count = shadow_count + COUNT_W'(1);
            end
         end
         CMD_POP_FRONT: begin
            if (shadow_count == '0) begin
               reply.status = ST_EMPTY;
            end else begin
               reply.pop_value = shadow_words[shadow_head];
               shadow_head = shadow_head + ADDR_W'(1);
               shadow_count = shadow_count - COUNT_W'(1);
            end
         end
         CMD_POP_BACK: begin
            if (shadow_count == '0) begin
               reply.status = ST_EMPTY;
            end else begin
               slot = shadow_head + shadow_count[ADDR_W-1:0] - ADDR_W'(1);
               reply.pop_value = shadow_words[slot];
               shadow_count = shadow_count - COUNT_W'(1);
            end
         end
         CMD_CLEAR: begin
            shadow_count = '0;
            shadow_head = '0;
         end
         default: begin
         end
      endcase
      reply.item_count = shadow_count;
      reply.is_empty = (shadow_count == '0);
      return reply;
   endfunction

   task automatic add_command(logic [2:0] code, logic [WORD_W-1:0] value, bit drain_first);
      queued_command_type entry;
      entry.beat.cmd = code;
      entry.beat.push_value = value;
      entry.drain_first = drain_first;
      command_backlog.push_back(entry);
   endtask

   function automatic logic [WORD_W-1:0] pick_word();
      logic [WORD_W-1:0] value;
      value = $urandom();
      if ($urandom_range(9) == 0) begin
         case ($urandom_range(3))
            0: value = WORD_MIN;
            1: value = WORD_MAX;
            2: value = '0;
            default: value = '1;
         endcase
      end
      return value;
   endfunction

   // Driver: a beat stays on the bus until it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
      end else begin
         if (req_valid && req_ready) begin
            commands_sent = commands_sent + 1;
         end
         if (!req_valid || req_ready) begin
            if (command_backlog.size() > 0 && (calm || $urandom_range(99) >= 10) &&
                !(command_backlog[0].drain_first && commands_sent != replies_seen)) begin
               req_data <= command_backlog[0].beat;
               req_valid <= 1'b1;
               void'(command_backlog.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= 10);
      end
   end

   // Monitor: predicts on every accepted request, checks every accepted response.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_replies.push_back(deque_step(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            replies_seen = replies_seen + 1;
            if (expected_replies.size() == 0) begin
               error_count = error_count + 1;
               if (error_count <= REPORT_CAP) begin
                  $display("%0t: response beat with nothing expected: %h", $time, rsp_data);
               end
            end else begin
               want = expected_replies.pop_front();
               if (rsp_data !== want) begin
                  error_count = error_count + 1;
                  if (error_count <= REPORT_CAP) begin
                     if (rsp_data.pop_value !== want.pop_value) begin
                        $display("%0t: pop_value expected %h got %h", $time,
                                 want.pop_value, rsp_data.pop_value);
                     end
                     if (rsp_data.status !== want.status) begin
                        $display("%0t: status expected %0d got %0d", $time,
                                 want.status, rsp_data.status);
                     end
                     if (rsp_data.item_count !== want.item_count) begin
                        $display("%0t: item_count expected %0d got %0d", $time,
                                 want.item_count, rsp_data.item_count);
                     end
                     if (rsp_data.is_empty !== want.is_empty) begin
                        $display("%0t: is_empty expected %b got %b", $time,
                                 want.is_empty, rsp_data.is_empty);
                     end
                  end
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int counted;
      int run_len;
      int mode;
      logic [2:0] code;

      // Directed part: empty-queue pops, extreme words, spare codes, fill past full.
      add_command(CMD_POP_FRONT, '1, 1'b0);
      add_command(CMD_POP_BACK, '1, 1'b0);
      add_command(CMD_PUSH_FRONT, WORD_MIN, 1'b0);
      add_command(CMD_PUSH_BACK, WORD_MAX, 1'b0);
      for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++) begin
         add_command(3'(c), '1, 1'b0);
      end
      add_command(CMD_POP_FRONT, '0, 1'b0);
      add_command(CMD_POP_BACK, '0, 1'b0);
      for (int n = 0; n < DEPTH; n++) begin
         add_command(n[0] ? CMD_PUSH_BACK : CMD_PUSH_FRONT, pick_word(), 1'b0);
      end
      add_command(CMD_PUSH_FRONT, '1, 1'b0);
      add_command(CMD_PUSH_BACK, '0, 1'b0);
      add_command(CMD_POP_BACK, '0, 1'b0);
      add_command(CMD_CLEAR, '1, 1'b0);
      add_command(CMD_POP_FRONT, '0, 1'b0);

      // Random part in bursts so the queue swings between empty and full.
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         mode = $urandom_range(9);
         run_len = $urandom_range(24, 4);
         for (int n = 0; n < run_len; n++) begin
            if (mode <= 2) begin
               code = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
            end else if (mode <= 5) begin
               code = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
            end else if (mode <= 8) begin
               code = ($urandom_range(39) == 0) ? CMD_CLEAR : 3'($urandom_range(CMD_POP_BACK));
            end else begin
               code = 3'($urandom_range(7));
            end
            // Now and then the sender holds off until the deque has answered everything.
            add_command(code, pick_word(), (counted % 300) == 0);
            if (code < CMD_SPARE_LO) begin
               counted++;
            end
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (command_backlog.size() != 0 || req_valid || expected_replies.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ files.f @@
sv/dequ_pkg.sv
sv/dequ_mem.sv
sv/dequ_ctrl.sv
sv/double_ended_queue_unit.sv
tb/sv/testbench.sv
